### rtl/core/tmmc_pkg.sv
`default_nettype none
package tmmc_pkg;

	// Sizes that follow from the fixed field widths.
	localparam int MAX_TILES_DEF = 32;
	localparam int MAX_DIM       = 4096;
	localparam int QUEUE_DEPTH   = 4;
	localparam int POS_W         = 12;
	localparam int ACC_W         = 18;
	localparam int DIM_W         = 13;
	localparam int GRID_W        = 6;
	localparam int TILE_W        = 5;
	localparam int CNT_W         = 25;
	localparam int MASK_W        = 32;
	localparam int TILES_W       = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_FRAME_WIDTH      = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_GRID_COLUMNS     = 3'd2;
	localparam logic [2:0] REG_GRID_ROWS        = 3'd3;
	localparam logic [2:0] REG_CHANGE_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_SPARSE_LIMIT     = 3'd5;
	localparam logic [2:0] REG_DENSE_LIMIT      = 3'd6;

	// Result status and workload class codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [1:0] CLS_SPARSE = 2'd0;
	localparam logic [1:0] CLS_DENSE  = 2'd1;
	localparam logic [1:0] CLS_MIXED  = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
		logic [GRID_W-1:0] grid_columns;
		logic [GRID_W-1:0] grid_rows;
		logic [7:0]        change_threshold;
		logic [GRID_W-1:0] sparse_limit;
		logic [GRID_W-1:0] dense_limit;
	} cfg_t;

	// One pixel event handed from the front to the back.
	typedef struct packed {
		logic              err;
		logic              chg;
		logic              fend;
		logic [TILE_W-1:0] tile;
	} ev_t;

	// Partial quotient of a tile coordinate, one bit resolved per stage.
	typedef struct packed {
		logic [ACC_W-1:0]  rem;
		logic [TILE_W-1:0] q;
		logic              sat;
	} div_t;

	typedef struct packed {
		logic valid;
		logic err;
		logic chg;
		logic fend;
		div_t col;
		div_t row;
	} fe_t;

	function automatic logic cfg_valid(cfg_t c, int max_tiles);
		logic [TILES_W-1:0] tiles;
		logic               ok;
		tiles = TILES_W'(c.grid_columns) * TILES_W'(c.grid_rows);
		ok = 1'b1;
		if (c.frame_width == '0 || c.frame_height == '0) ok = 1'b0;
		if ({1'b0, c.frame_width} > 14'(MAX_DIM)) ok = 1'b0;
		if ({1'b0, c.frame_height} > 14'(MAX_DIM)) ok = 1'b0;
		if (c.grid_columns == '0 || c.grid_rows == '0) ok = 1'b0;
		if (tiles > TILES_W'(max_tiles)) ok = 1'b0;
		if (tiles > TILES_W'(MASK_W)) ok = 1'b0;
		if (c.sparse_limit >= c.dense_limit) ok = 1'b0;
		if (TILES_W'(c.dense_limit) > tiles) ok = 1'b0;
		return ok;
	endfunction

	// One restoring step: resolve quotient bit b against span << b.
	function automatic div_t div_step(div_t d, logic [DIM_W-1:0] span, int b);
		logic [ACC_W-1:0] sh;
		div_t             r;
		sh = ACC_W'(span) << b;
		r = d;
		if (d.rem >= sh) begin
			r.rem  = d.rem - sh;
			r.q[b] = 1'b1;
		end
		return r;
	endfunction

	function automatic fe_t fe_step(fe_t s, logic [DIM_W-1:0] fw, logic [DIM_W-1:0] fh,
			int b);
		fe_t r;
		r = s;
		r.col = div_step(s.col, fw, b);
		r.row = div_step(s.row, fh, b);
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/tmmc_if.sv
`default_nettype none
interface tmmc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] prev_pixel;
	logic [7:0] cur_pixel;

	modport source (output valid, output prev_pixel, output cur_pixel, input ready);
	modport sink (input valid, input prev_pixel, input cur_pixel, output ready);
endinterface

interface tmmc_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [4:0]  tile_index;
	logic [24:0] tile_changed;
	logic [31:0] motion_mask;
	logic [5:0]  active_sum;
	logic [4:0]  low_half_active;
	logic [4:0]  high_half_active;
	logic [24:0] frame_changed;
	logic [1:0]  path_class;
	logic        last;

	modport source (output valid, output status, output tile_index, output tile_changed,
		output motion_mask, output active_sum, output low_half_active,
		output high_half_active, output frame_changed, output path_class, output last,
		input ready);
	modport sink (input valid, input status, input tile_index, input tile_changed,
		input motion_mask, input active_sum, input low_half_active,
		input high_half_active, input frame_changed, input path_class, input last,
		output ready);
endinterface
`default_nettype wire

### rtl/core/tmmc_front.sv
`default_nettype none
module tmmc_front #(
	parameter int MAX_TILES = tmmc_pkg::MAX_TILES_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	tmmc_pix_if.sink          pix,
	input  tmmc_pkg::cfg_t    cfg,
	output tmmc_pkg::ev_t     ev,
	output logic              ev_valid,
	input  wire               q_full
);
	import tmmc_pkg::*;

	logic [POS_W-1:0] col_pos_q, row_pos_q;
	logic [ACC_W-1:0] col_acc_q, row_acc_q;
	fe_t              fe_s1, fe_s2, fe_s3, fe_s4, fe_s5, fe_s6;
	fe_t              cap;
	logic             advance, accept, ok, row_end, frame_end;
	logic [7:0]       diff;
	logic [TILE_W-1:0] col_qt, row_qt, col_t, row_t;
	logic [GRID_W-1:0] col_lim, row_lim;
	logic [10:0]      tile_full;

	assign advance   = !(fe_s6.valid && q_full);
	assign pix.ready = advance;
	assign accept    = pix.valid && advance;
	assign ok        = cfg_valid(cfg, MAX_TILES);

	always_comb begin
		diff = (pix.cur_pixel > pix.prev_pixel) ? pix.cur_pixel - pix.prev_pixel
			: pix.prev_pixel - pix.cur_pixel;
		row_end   = {1'b0, col_pos_q} >= (cfg.frame_width - DIM_W'(1));
		frame_end = row_end && ({1'b0, row_pos_q} >= (cfg.frame_height - DIM_W'(1)));

		cap         = '0;
		cap.valid   = pix.valid;
		cap.err     = !ok;
		cap.chg     = diff > cfg.change_threshold;
		cap.fend    = frame_end;
		cap.col.rem = col_acc_q;
		cap.col.sat = col_acc_q >= (ACC_W'(cfg.frame_width) << TILE_W);
		cap.row.rem = row_acc_q;
		cap.row.sat = row_acc_q >= (ACC_W'(cfg.frame_height) << TILE_W);
	end

	// Position and boundary accumulators, updated once per accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
		end else if (accept) begin
			if (!ok || frame_end) begin
				col_pos_q <= '0;
				row_pos_q <= '0;
				col_acc_q <= '0;
				row_acc_q <= '0;
			end else if (row_end) begin
				col_pos_q <= '0;
				col_acc_q <= '0;
				row_pos_q <= row_pos_q + POS_W'(1);
				row_acc_q <= row_acc_q + ACC_W'(cfg.grid_rows);
			end else begin
				col_pos_q <= col_pos_q + POS_W'(1);
				col_acc_q <= col_acc_q + ACC_W'(cfg.grid_columns);
			end
		end
	end

	// Tile coordinate pipeline: a capture stage, then one quotient bit per stage, MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_s1 <= '0;
			fe_s2 <= '0;
			fe_s3 <= '0;
			fe_s4 <= '0;
			fe_s5 <= '0;
			fe_s6 <= '0;
		end else if (advance) begin
			fe_s1 <= cap;
			fe_s2 <= fe_step(fe_s1, cfg.frame_width, cfg.frame_height, 4);
			fe_s3 <= fe_step(fe_s2, cfg.frame_width, cfg.frame_height, 3);
			fe_s4 <= fe_step(fe_s3, cfg.frame_width, cfg.frame_height, 2);
			fe_s5 <= fe_step(fe_s4, cfg.frame_width, cfg.frame_height, 1);
			fe_s6 <= fe_step(fe_s5, cfg.frame_width, cfg.frame_height, 0);
		end
	end

	// Clamp to the last tile and form the row-major index.
	always_comb begin
		col_qt  = fe_s6.col.sat ? {TILE_W{1'b1}} : fe_s6.col.q;
		row_qt  = fe_s6.row.sat ? {TILE_W{1'b1}} : fe_s6.row.q;
		col_lim = cfg.grid_columns - GRID_W'(1);
		row_lim = cfg.grid_rows - GRID_W'(1);
		col_t   = ({1'b0, col_qt} > col_lim) ? col_lim[TILE_W-1:0] : col_qt;
		row_t   = ({1'b0, row_qt} > row_lim) ? row_lim[TILE_W-1:0] : row_qt;
		tile_full = 11'(row_t) * 11'(cfg.grid_columns) + 11'(col_t);

		ev.err  = fe_s6.err;
		ev.chg  = fe_s6.chg;
		ev.fend = fe_s6.fend;
		ev.tile = tile_full[TILE_W-1:0];
		ev_valid = fe_s6.valid;
	end

endmodule
`default_nettype wire

### rtl/core/tmmc_queue.sv
`default_nettype none
module tmmc_queue #(
	parameter int DEPTH = tmmc_pkg::QUEUE_DEPTH
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  tmmc_pkg::ev_t wr_data,
	output logic          full,
	input  wire           pop,
	output tmmc_pkg::ev_t rd_data,
	output logic          empty
);
	import tmmc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	ev_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = count_q == CNT_QW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/tmmc_back.sv
`default_nettype none
module tmmc_back #(
	parameter int MAX_TILES = tmmc_pkg::MAX_TILES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  tmmc_pkg::cfg_t cfg,
	input  tmmc_pkg::ev_t  head,
	input  wire            q_empty,
	output logic           q_pop,
	tmmc_res_if.source     res
);
	import tmmc_pkg::*;

	localparam int TIDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

	localparam logic [1:0] BK_RUN  = 2'd0;
	localparam logic [1:0] BK_SUM  = 2'd1;
	localparam logic [1:0] BK_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q [MAX_TILES];
	logic [MASK_W-1:0]  mask_q;
	logic [CNT_W-1:0]   total_q;
	logic [TILE_W-1:0]  k_q;
	logic [5:0]         act_q;
	logic [4:0]         low_q, high_q;
	logic [1:0]         cls_q;
	logic [TILES_W-1:0] tiles;
	logic [4:0]         low_c, high_c;
	logic [5:0]         act_c;
	logic               out_free, run_pop, inc, emit_ld, emit_last, clear;

	logic               res_valid_q;
	logic               status_q, last_q;
	logic [TILE_W-1:0]  index_q;
	logic [CNT_W-1:0]   tchg_q, fchg_q;
	logic [MASK_W-1:0]  rmask_q;
	logic [5:0]         ract_q;
	logic [4:0]         rlow_q, rhigh_q;
	logic [1:0]         rcls_q;

	always_comb begin
		tiles     = TILES_W'(cfg.grid_columns) * TILES_W'(cfg.grid_rows);
		out_free  = !res_valid_q || res.ready;
		run_pop   = (state_q == BK_RUN) && !q_empty && (!head.err || out_free);
		inc       = run_pop && !head.err && head.chg;
		emit_ld   = (state_q == BK_EMIT) && out_free;
		emit_last = TILES_W'(k_q) == (tiles - TILES_W'(1));
		clear     = (run_pop && head.err) || (emit_ld && emit_last);
		low_c     = 5'($countones(mask_q[15:0]));
		high_c    = 5'($countones(mask_q[31:16]));
		act_c     = {1'b0, low_c} + {1'b0, high_c};
	end

	assign q_pop = run_pop;

	// One saturating counter cell per tile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TILES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MAX_TILES; i++) begin
				if (clear) begin
					cnt_q[i] <= '0;
				end else if (inc && head.tile == TILE_W'(i) && cnt_q[i] != CNT_MAX) begin
					cnt_q[i] <= cnt_q[i] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			total_q <= '0;
		end else if (clear) begin
			mask_q  <= '0;
			total_q <= '0;
		end else if (inc) begin
			mask_q <= mask_q | (MASK_W'(1) << head.tile);
			if (total_q != CNT_MAX) begin
				total_q <= total_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				BK_RUN: begin
					if (run_pop && !head.err && head.fend) begin
						state_q <= BK_SUM;
					end
				end
				BK_SUM: begin
					k_q     <= '0;
					state_q <= BK_EMIT;
				end
				BK_EMIT: begin
					if (emit_ld) begin
						if (emit_last) begin
							state_q <= BK_RUN;
						end else begin
							k_q <= k_q + TILE_W'(1);
						end
					end
				end
				default: state_q <= BK_RUN;
			endcase
		end
	end

	// Frame totals, taken once the final increment has landed.
	always_ff @(posedge clk) begin
		if (state_q == BK_SUM) begin
			low_q  <= low_c;
			high_q <= high_c;
			act_q  <= act_c;
			priority if (act_c <= cfg.sparse_limit) begin
				cls_q <= CLS_SPARSE;
			end else if (act_c >= cfg.dense_limit) begin
				cls_q <= CLS_DENSE;
			end else begin
				cls_q <= CLS_MIXED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((run_pop && head.err) || emit_ld) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_pop && head.err) begin
			status_q <= STATUS_ERR;
			index_q  <= '0;
			tchg_q   <= '0;
			rmask_q  <= '0;
			ract_q   <= '0;
			rlow_q   <= '0;
			rhigh_q  <= '0;
			fchg_q   <= '0;
			rcls_q   <= CLS_SPARSE;
			last_q   <= 1'b1;
		end else if (emit_ld) begin
			status_q <= STATUS_OK;
			index_q  <= k_q;
			tchg_q   <= cnt_q[k_q[TIDX_W-1:0]];
			rmask_q  <= mask_q;
			ract_q   <= act_q;
			rlow_q   <= low_q;
			rhigh_q  <= high_q;
			fchg_q   <= total_q;
			rcls_q   <= cls_q;
			last_q   <= emit_last;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.status           = status_q;
	assign res.tile_index       = index_q;
	assign res.tile_changed     = tchg_q;
	assign res.motion_mask      = rmask_q;
	assign res.active_sum       = ract_q;
	assign res.low_half_active  = rlow_q;
	assign res.high_half_active = rhigh_q;
	assign res.frame_changed    = fchg_q;
	assign res.path_class       = rcls_q;
	assign res.last             = last_q;

endmodule
`default_nettype wire

### rtl/core/tile_motion_mask_classifier.sv
// Tile motion mask classifier.
//
// The pix channel takes one transfer per pixel pair (previous and current grey value) in
// raster order; the block counts column and row itself, so the first transfer after reset
// or after a frame's last pixel is the top-left pixel. A pixel whose absolute difference
// exceeds change_threshold counts against its tile on an even grid of tiles. Registers go
// through cfg_we / cfg_index / cfg_data, one per cycle; the user writes them only while
// the block is idle, which the block itself does not enforce.
//
// Throughput: one pixel per cycle while the event queue has room. Tile coordinates come
// from a six-stage pipeline, a capture stage and then one quotient bit per stage, and go
// through the queue to the counters. On the last pixel of a frame the back end forms the
// mask totals in state BK_SUM and then puts out one result per tile on the res channel,
// one per cycle unless res stalls, the last one flagged. Meanwhile the pixel front keeps
// running into a four-entry event queue and stalls only when that fills. An invalid
// configuration turns each pixel into a single error result and restarts the frame.
//
// Reset clears position, counters, mask and all valid flags and loads the default
// configuration. A stall on res holds the output register; while results remain to be
// loaded the back end stops draining the queue and the stall spreads back to pix.ready.
`default_nettype none
module tile_motion_mask_classifier #(
	parameter int MAX_TILES   = tmmc_pkg::MAX_TILES_DEF,
	parameter int QUEUE_DEPTH = tmmc_pkg::QUEUE_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	tmmc_pix_if.sink   pix,
	tmmc_res_if.source res,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [12:0] cfg_data
);
	import tmmc_pkg::*;

	cfg_t cfg_q;
	ev_t  ev, head;
	logic ev_valid, q_full, q_empty, q_pop;

	// Configuration registers; a write to an unused index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width      <= DIM_W'(640);
			cfg_q.frame_height     <= DIM_W'(480);
			cfg_q.grid_columns     <= GRID_W'(8);
			cfg_q.grid_rows        <= GRID_W'(4);
			cfg_q.change_threshold <= 8'd12;
			cfg_q.sparse_limit     <= GRID_W'(4);
			cfg_q.dense_limit      <= GRID_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:      cfg_q.frame_width      <= cfg_data;
				REG_FRAME_HEIGHT:     cfg_q.frame_height     <= cfg_data;
				REG_GRID_COLUMNS:     cfg_q.grid_columns     <= cfg_data[GRID_W-1:0];
				REG_GRID_ROWS:        cfg_q.grid_rows        <= cfg_data[GRID_W-1:0];
				REG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data[7:0];
				REG_SPARSE_LIMIT:     cfg_q.sparse_limit     <= cfg_data[GRID_W-1:0];
				REG_DENSE_LIMIT:      cfg_q.dense_limit      <= cfg_data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	tmmc_front #(
		.MAX_TILES(MAX_TILES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.cfg      (cfg_q),
		.ev       (ev),
		.ev_valid (ev_valid),
		.q_full   (q_full)
	);

	tmmc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ev_valid),
		.wr_data (ev),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	tmmc_back #(
		.MAX_TILES(MAX_TILES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
`default_nettype wire
